// ===== src/hcsg_pkg.sv =====
// Package of the hop channel sequence generator: sizes, generator constants,
// microcode types and the control program itself.
// No dependencies; every other file of the block imports it.
package hcsg_pkg;

	localparam int SEQ_LEN = 23;
	localparam int CNT_W   = $clog2(SEQ_LEN + 1);
	localparam int ADDR_W  = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;

	localparam int ID_W  = 32;
	localparam int CH_W  = 7;
	localparam int POS_W = 5;
	localparam int BC_W  = 4;

	localparam logic [31:0] LCG_MUL = 32'h0019_660D;
	localparam logic [31:0] LCG_ADD = 32'h3C6E_F35F;

	// floor(2^30 / 73): the quotient estimate is exact or one low.
	localparam logic [23:0] RECIP    = 24'd14708792;
	localparam int          RECIP_SH = 30;

	localparam logic [7:0]      CH_SPAN      = 8'h49;
	localparam logic [CH_W-1:0] CH_BASE      = 7'd3;
	localparam logic [CH_W-1:0] BAND_LO_TOP  = 7'd27;
	localparam logic [CH_W-1:0] BAND_MID_TOP = 7'd51;
	localparam logic [BC_W-1:0] BAND_LO_MAX  = 4'd8;
	localparam logic [BC_W-1:0] BAND_MID_MAX = 4'd7;
	localparam logic [BC_W-1:0] BAND_HI_MAX  = 4'd8;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SEED,
		OP_LCG,
		OP_RECIP,
		OP_REM,
		OP_CHAN,
		OP_CLRIDX,
		OP_READ,
		OP_WRITE,
		OP_LOAD_OUT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_REJECT,
		C_IDX_EQ_CNT,
		C_NOT_DUP,
		C_MORE,
		C_IDX_NE_LEN
	} cond_t;

	typedef enum logic [1:0] {
		H_NONE,
		H_IN,
		H_OUT
	} hold_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_IDLE  = 4'd0;
	localparam pc_t PC_LCG   = 4'd1;
	localparam pc_t PC_RECIP = 4'd2;
	localparam pc_t PC_REM   = 4'd3;
	localparam pc_t PC_CHAN  = 4'd4;
	localparam pc_t PC_TEST  = 4'd5;
	localparam pc_t PC_SCAN  = 4'd6;
	localparam pc_t PC_CMP   = 4'd7;
	localparam pc_t PC_REJ   = 4'd8;
	localparam pc_t PC_ACC   = 4'd9;
	localparam pc_t PC_ESET  = 4'd10;
	localparam pc_t PC_ERD   = 4'd11;
	localparam pc_t PC_EOUT  = 4'd12;
	localparam pc_t PC_END   = 4'd13;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		hold_t hold;
		pc_t   target;
	} ucode_t;

	// Datapath controls issued by the sequencer for the current cycle.
	typedef struct packed {
		op_t  op;
		logic id_ready;
	} ctrl_t;

	// Datapath conditions that the sequencer branches or waits on.
	typedef struct packed {
		logic id_fire;
		logic out_free;
		logic reject;
		logic idx_eq_cnt;
		logic not_dup;
		logic more;
		logic idx_ne_len;
	} stat_t;

	// The control program. A step that holds does nothing until its wait ends;
	// then it runs its operation and jumps to target if its condition is true.
	function automatic ucode_t rom_word(input pc_t pc);
		ucode_t w;
		begin
			unique case (pc)
				PC_IDLE:  w = '{OP_SEED,     C_NEVER,      H_IN,   PC_IDLE};
				PC_LCG:   w = '{OP_LCG,      C_NEVER,      H_NONE, PC_IDLE};
				PC_RECIP: w = '{OP_RECIP,    C_NEVER,      H_NONE, PC_IDLE};
				PC_REM:   w = '{OP_REM,      C_NEVER,      H_NONE, PC_IDLE};
				PC_CHAN:  w = '{OP_CHAN,     C_NEVER,      H_NONE, PC_IDLE};
				PC_TEST:  w = '{OP_CLRIDX,   C_REJECT,     H_NONE, PC_LCG};
				PC_SCAN:  w = '{OP_READ,     C_IDX_EQ_CNT, H_NONE, PC_ACC};
				PC_CMP:   w = '{OP_NOP,      C_NOT_DUP,    H_NONE, PC_SCAN};
				PC_REJ:   w = '{OP_NOP,      C_ALWAYS,     H_NONE, PC_LCG};
				PC_ACC:   w = '{OP_WRITE,    C_MORE,       H_NONE, PC_LCG};
				PC_ESET:  w = '{OP_CLRIDX,   C_NEVER,      H_NONE, PC_IDLE};
				PC_ERD:   w = '{OP_READ,     C_NEVER,      H_NONE, PC_IDLE};
				PC_EOUT:  w = '{OP_LOAD_OUT, C_IDX_NE_LEN, H_OUT,  PC_ERD};
				PC_END:   w = '{OP_NOP,      C_ALWAYS,     H_NONE, PC_IDLE};
				default:  w = '{OP_NOP,      C_ALWAYS,     H_NONE, PC_IDLE};
			endcase
			return w;
		end
	endfunction

endpackage

// ===== src/hcsg_ifs.sv =====
// Channel interfaces of the hop channel sequence generator: the id channel
// and the hop channel, each with valid, ready and payload.
// Depends on hcsg_pkg for the field widths.
interface hcsg_id_if import hcsg_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] radio_id;

	modport source (output valid, output radio_id, input ready);
	modport sink (input valid, input radio_id, output ready);
endinterface

interface hcsg_hop_if import hcsg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  channel;
	logic [POS_W-1:0] position;
	logic             last;

	modport source (output valid, output channel, output position, output last, input ready);
	modport sink (input valid, input channel, input position, input last, output ready);
endinterface

// ===== src/hcsg_sequencer.sv =====
// Microcode sequencer of the hop channel sequence generator: step counter,
// program table lookup, waits and conditional jumps.
// Depends on hcsg_pkg for the program and the control and status types.
module hcsg_sequencer import hcsg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	pc_t    pc_q;
	ucode_t word;
	logic   held;
	logic   taken;

	assign word = rom_word(pc_q);

	always_comb begin
		unique case (word.hold)
			H_IN:    held = !stat.id_fire;
			H_OUT:   held = !stat.out_free;
			default: held = 1'b0;
		endcase
	end

	always_comb begin
		unique case (word.cond)
			C_ALWAYS:     taken = 1'b1;
			C_REJECT:     taken = stat.reject;
			C_IDX_EQ_CNT: taken = stat.idx_eq_cnt;
			C_NOT_DUP:    taken = stat.not_dup;
			C_MORE:       taken = stat.more;
			C_IDX_NE_LEN: taken = stat.idx_ne_len;
			default:      taken = 1'b0;
		endcase
	end

	assign ctrl.op       = held ? OP_NOP : word.op;
	assign ctrl.id_ready = (word.hold == H_IN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (!held) begin
			pc_q <= taken ? word.target : pc_q + 1'b1;
		end
	end

endmodule

// ===== src/hop_channel_sequence_generator.sv =====
// Top level of the hop channel sequence generator: datapath, hop list memory
// and output register, steered by the microcode sequencer.
// Depends on hcsg_pkg, hcsg_ifs and hcsg_sequencer.
//
//  channel  | role   | payload                  | per item
//  ---------+--------+--------------------------+---------------------------
//  id_ch    | sink   | radio_id[31:0]           | starts one hop sequence
//  hop_ch   | source | channel, position, last  | 23 items per id item
//
// Each candidate draw runs the generator step, reciprocal multiply, remainder,
// channel, and parity and band test steps, plus a duplicate scan over the N
// channels accepted so far when it passes. The time for a whole id item is set
// by the number of draws and the scan loop over the single hop list read port;
// then each result takes a read step and an output step. The id channel is
// ready only while the program waits in its idle step; it may accept a new id
// while the last result still sits in the output register. Reset clears the
// step counter, the counters and the output valid; the hop list needs no
// clearing since only entries written for the current id are compared or sent.
// A stalled sink holds the output step until the output register is free.
module hop_channel_sequence_generator import hcsg_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	hcsg_id_if.sink     id_ch,
	hcsg_hop_if.source  hop_ch
);

	ctrl_t ctrl;
	stat_t stat;

	// Generator and candidate registers.
	logic [ID_W-1:0]  seed_q;
	logic [31:0]      lcg_q;
	logic [17:0]      quo_q;
	logic [7:0]       rem_q;
	logic [CH_W-1:0]  ch_q;

	// Counters: accepted channels, scan or emit index, and channels per band.
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [BC_W-1:0]  lo_q;
	logic [BC_W-1:0]  mid_q;
	logic [BC_W-1:0]  hi_q;

	// Hop list and its registered read port.
	logic [CH_W-1:0]  hop_mem [SEQ_LEN];
	logic [CH_W-1:0]  rd_q;

	// Output register.
	logic             out_valid_q;
	logic [CH_W-1:0]  out_ch_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_last_q;

	logic [23:0]      draw;
	logic [47:0]      prod;
	logic [23:0]      back;
	logic [23:0]      diff;
	logic [7:0]       rem_fix;
	logic             is_lo;
	logic             is_mid;
	logic             band_full;

	hcsg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// The candidate is CH_BASE + (state >> 8) mod 73: a reciprocal multiply gives
	// the quotient, possibly one low, and a single subtract corrects the remainder.
	assign draw    = lcg_q[31:8];
	assign prod    = 48'(draw) * 48'(RECIP);
	assign back    = 24'(quo_q) * 24'(CH_SPAN);
	assign diff    = draw - back;
	assign rem_fix = (rem_q >= CH_SPAN) ? rem_q - CH_SPAN : rem_q;

	assign is_lo  = (ch_q <= BAND_LO_TOP);
	assign is_mid = !is_lo && (ch_q <= BAND_MID_TOP);

	always_comb begin
		priority if (is_lo) begin
			band_full = (lo_q >= BAND_LO_MAX);
		end else if (is_mid) begin
			band_full = (mid_q >= BAND_MID_MAX);
		end else begin
			band_full = (hi_q >= BAND_HI_MAX);
		end
	end

	assign stat.id_fire    = id_ch.valid && ctrl.id_ready;
	assign stat.out_free   = !out_valid_q || hop_ch.ready;
	assign stat.reject     = (ch_q[0] == seed_q[0]) || band_full;
	assign stat.idx_eq_cnt = (idx_q == cnt_q);
	assign stat.not_dup    = (rd_q != ch_q);
	assign stat.more       = (cnt_q != CNT_W'(SEQ_LEN - 1));
	assign stat.idx_ne_len = (idx_q != CNT_W'(SEQ_LEN));

	assign id_ch.ready = ctrl.id_ready;

	// Payload registers of the generator.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_SEED: begin
				seed_q <= ~id_ch.radio_id;
				lcg_q  <= ~id_ch.radio_id;
			end
			OP_LCG:   lcg_q <= lcg_q * LCG_MUL + LCG_ADD;
			OP_RECIP: quo_q <= prod[RECIP_SH +: 18];
			OP_REM:   rem_q <= diff[7:0];
			OP_CHAN:  ch_q  <= rem_fix[CH_W-1:0] + CH_BASE;
			default: begin
			end
		endcase
	end

	// The accepted count and band counters are cleared for every new id.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			lo_q  <= '0;
			mid_q <= '0;
			hi_q  <= '0;
		end else begin
			unique case (ctrl.op)
				OP_SEED: begin
					cnt_q <= '0;
					lo_q  <= '0;
					mid_q <= '0;
					hi_q  <= '0;
				end
				OP_CLRIDX: idx_q <= '0;
				OP_READ:   idx_q <= idx_q + 1'b1;
				OP_WRITE: begin
					cnt_q <= cnt_q + 1'b1;
					priority if (is_lo) begin
						lo_q <= lo_q + 1'b1;
					end else if (is_mid) begin
						mid_q <= mid_q + 1'b1;
					end else begin
						hi_q <= hi_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_WRITE) begin
			hop_mem[cnt_q[ADDR_W-1:0]] <= ch_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_READ) begin
			rd_q <= hop_mem[idx_q[ADDR_W-1:0]];
		end
	end

	// The emit index has already moved past the entry that was read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_LOAD_OUT) begin
			out_valid_q <= 1'b1;
		end else if (hop_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_LOAD_OUT) begin
			out_ch_q   <= rd_q;
			out_pos_q  <= POS_W'(idx_q - 1'b1);
			out_last_q <= (idx_q == CNT_W'(SEQ_LEN));
		end
	end

	assign hop_ch.valid    = out_valid_q;
	assign hop_ch.channel  = out_ch_q;
	assign hop_ch.position = out_pos_q;
	assign hop_ch.last     = out_last_q;

	// The band counters always add up to the number of accepted channels.
	a_band_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(6'(lo_q) + 6'(mid_q) + 6'(hi_q)) == 6'(cnt_q))
		else $error("band counters disagree with accepted count");

	// A channel is only written into a band that still has room, and the
	// list never overflows.
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_WRITE) |-> (!band_full && (cnt_q < CNT_W'(SEQ_LEN))))
		else $error("hop list write into a full band or past the end");

	// A new id restarts the sequence with empty counters.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		stat.id_fire |=> (cnt_q == '0) && (lo_q == '0) && (mid_q == '0) && (hi_q == '0))
		else $error("counters not cleared for a new id");

endmodule

// ===== sim/tb_hop_channel_sequence_generator.sv =====
`timescale 1ns / 1ps
// Testbench of the hop channel sequence generator: drives transmitter ids and
// checks every hop channel item against a predicted sequence.
// Depends on hcsg_pkg, hcsg_ifs and the hop_channel_sequence_generator top.

// Keeps the hop items still owed by the block, oldest first. Each accepted id
// is expanded into its full 23-entry hop sequence when it is accepted.
class hop_scoreboard;
	typedef struct {
		logic [hcsg_pkg::CH_W-1:0]  channel;
		logic [hcsg_pkg::POS_W-1:0] position;
		logic                       last;
	} hop_item_t;

	hop_item_t expected_hops[$];
	int        mismatches;

	function new();
		mismatches = 0;
	endfunction

	function int outstanding();
		return expected_hops.size();
	endfunction

	// Runs the seeded generator until the sequence is full and queues the hops.
	function void add_id(input logic [hcsg_pkg::ID_W-1:0] radio_id);
		logic [31:0]               seed;
		logic [31:0]               lcg;
		logic [31:0]               rem;
		logic [hcsg_pkg::CH_W-1:0] cand;
		logic [hcsg_pkg::CH_W-1:0] hops [hcsg_pkg::SEQ_LEN];
		int                        filled;
		int                        n_lo;
		int                        n_mid;
		int                        n_hi;
		bit                        dup;
		bit                        room;
		hop_item_t                 item;
		seed = ~radio_id;
		lcg = seed;
		filled = 0;
		while (filled < hcsg_pkg::SEQ_LEN) begin
			lcg = lcg * hcsg_pkg::LCG_MUL + hcsg_pkg::LCG_ADD;
			rem = (lcg >> 8) % {24'd0, hcsg_pkg::CH_SPAN};
			cand = rem[hcsg_pkg::CH_W-1:0] + hcsg_pkg::CH_BASE;
			// A candidate must have the opposite low bit of the seed.
			if (cand[0] == seed[0])
				continue;
			dup = 1'b0;
			n_lo = 0;
			n_mid = 0;
			n_hi = 0;
			for (int k = 0; k < filled; k++) begin
				if (hops[k] == cand)
					dup = 1'b1;
				if (hops[k] <= hcsg_pkg::BAND_LO_TOP)
					n_lo++;
				else if (hops[k] <= hcsg_pkg::BAND_MID_TOP)
					n_mid++;
				else
					n_hi++;
			end
			if (cand <= hcsg_pkg::BAND_LO_TOP)
				room = n_lo < int'(hcsg_pkg::BAND_LO_MAX);
			else if (cand <= hcsg_pkg::BAND_MID_TOP)
				room = n_mid < int'(hcsg_pkg::BAND_MID_MAX);
			else
				room = n_hi < int'(hcsg_pkg::BAND_HI_MAX);
			if (!dup && room) begin
				hops[filled] = cand;
				filled++;
			end
		end
		for (int k = 0; k < hcsg_pkg::SEQ_LEN; k++) begin
			item.channel = hops[k];
			item.position = k[hcsg_pkg::POS_W-1:0];
			item.last = (k == hcsg_pkg::SEQ_LEN - 1);
			expected_hops.push_back(item);
		end
	endfunction

	function void check_hop(input logic [hcsg_pkg::CH_W-1:0] channel,
		input logic [hcsg_pkg::POS_W-1:0] position, input logic last);
		hop_item_t want;
		if (expected_hops.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected hop item channel=%0d position=%0d last=%0b",
				$time, channel, position, last);
			return;
		end
		want = expected_hops.pop_front();
		if (channel !== want.channel) begin
			mismatches++;
			$display("%0t: channel mismatch at position %0d: expected %0d, got %0d",
				$time, want.position, want.channel, channel);
		end
		if (position !== want.position) begin
			mismatches++;
			$display("%0t: position mismatch: expected %0d, got %0d",
				$time, want.position, position);
		end
		if (last !== want.last) begin
			mismatches++;
			$display("%0t: last mismatch at position %0d: expected %0b, got %0b",
				$time, want.position, want.last, last);
		end
	endfunction
endclass

module tb_hop_channel_sequence_generator import hcsg_pkg::*; ;

	// A single id runs its draws and duplicate scans, and the sink may stall each
	// of its 23 hop items, so the cycle limit is set far above the slowest
	// expected run of about 200 ids.
	localparam int CYCLE_LIMIT  = 6_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_IDS   = 188;
	localparam int PAUSE_EVERY  = 47;

	logic clk;
	logic arst_n;
	int   cycles = 0;

	hcsg_id_if  id_ch ();
	hcsg_hop_if hop_ch ();

	hop_scoreboard sb;

	hop_channel_sequence_generator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.id_ch  (id_ch),
		.hop_ch (hop_ch)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a generator that never fills its list ends
	// the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return 0;
		else if (roll < 85)
			return $urandom_range(4, 1);
		else if (roll < 96)
			return $urandom_range(20, 5);
		else
			return $urandom_range(300, 50);
	endfunction

	// Presents one id after a random gap and holds it until the block takes it.
	// A zero gap keeps valid high, so ids go in back to back.
	task automatic send_id(input logic [ID_W-1:0] radio_id);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			id_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		id_ch.valid <= 1'b1;
		id_ch.radio_id <= radio_id;
		do @(posedge clk); while (!id_ch.ready);
		sb.add_id(radio_id);
	endtask

	// Sink behavior: ready in bursts of random length, broken by stalls.
	// Occasional long bursts give stretches with no back-pressure at all.
	task automatic run_sink();
		int burst;
		int stall;
		forever begin
			burst = ($urandom_range(9) == 0) ? $urandom_range(400, 100)
				: $urandom_range(8, 1);
			hop_ch.ready <= 1'b1;
			repeat (burst) @(posedge clk);
			stall = pick_gap();
			if (stall == 0)
				stall = 1;
			hop_ch.ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	endtask

	// Every accepted hop item is checked against the oldest expectation. The
	// values read here are those from before the edge, so the order of events
	// inside the time step does not matter.
	always @(posedge clk) begin
		if (arst_n && hop_ch.valid && hop_ch.ready)
			sb.check_hop(hop_ch.channel, hop_ch.position, hop_ch.last);
	end

	// The directed ids hit the all-zero and all-one ids (both seed parities),
	// single-bit and alternating patterns, and a repeated id to show that every
	// new id restarts the generator from scratch.
	logic [ID_W-1:0] directed_ids [12] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
		32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
		32'h1234_5678, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_F0F0
	};

	initial begin
		sb = new();
		arst_n = 1'b0;
		id_ch.valid = 1'b0;
		id_ch.radio_id = '0;
		hop_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fork
			run_sink();
		join_none

		foreach (directed_ids[i])
			send_id(directed_ids[i]);

		for (int n = 0; n < RANDOM_IDS; n++) begin
			// Now and then the sender waits for the whole backlog to drain,
			// so the block also starts from a fully idle output side.
			if (n % PAUSE_EVERY == PAUSE_EVERY - 1) begin
				id_ch.valid <= 1'b0;
				@(posedge clk);
				while (sb.outstanding() != 0)
					@(posedge clk);
			end
			send_id($urandom);
		end
		id_ch.valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		// Extra cycles catch any hop item the block sends beyond the sequence.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== hop_channel_sequence_generator.f =====
src/hcsg_pkg.sv
src/hcsg_ifs.sv
src/hcsg_sequencer.sv
src/hop_channel_sequence_generator.sv
sim/tb_hop_channel_sequence_generator.sv
